// File: src/psdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Point splat depth raster package
// Command codes, register indexes, neighbour offsets and the pixel layout.
// ----------------------------------------------------------------------------
package psdr_pkg;

  localparam logic [1:0] CMD_SPLAT = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [2:0] REG_X_ORIGIN   = 3'd0;
  localparam logic [2:0] REG_Y_ORIGIN   = 3'd1;
  localparam logic [2:0] REG_Z_FLOOR    = 3'd2;
  localparam logic [2:0] REG_X_PITCH    = 3'd3;
  localparam logic [2:0] REG_Y_PITCH    = 3'd4;
  localparam logic [2:0] REG_GRAY_SCALE = 3'd5;
  localparam logic [2:0] REG_ROWS_USED  = 3'd6;
  localparam logic [2:0] REG_COLS_USED  = 3'd7;

  localparam logic [1:0] OFS_ZERO = 2'd0;
  localparam logic [1:0] OFS_DEC  = 2'd1;
  localparam logic [1:0] OFS_INC  = 2'd2;

  localparam logic [2:0] GRP_CTR = 3'd0;
  localparam logic [2:0] GRP_A   = 3'd1;
  localparam logic [2:0] GRP_B   = 3'd2;
  localparam logic [2:0] GRP_C   = 3'd3;
  localparam logic [2:0] GRP_D   = 3'd4;

  localparam logic [3:0] NB_LAST = 4'd8;
  localparam int unsigned GRAY_MAX = 255;

  typedef struct packed {
    logic [7:0]  inten;
    logic [7:0]  gray;
    logic [31:0] depth;
  } pixel_t;

  typedef struct packed {
    logic [1:0] row_ofs;
    logic [1:0] col_ofs;
    logic [2:0] grp;
  } nb_t;

  function automatic nb_t nb_entry(input logic [3:0] k);
    nb_t e;
    unique case (k)
      4'd0:    e = '{OFS_ZERO, OFS_ZERO, GRP_CTR};
      4'd1:    e = '{OFS_DEC,  OFS_ZERO, GRP_A};
      4'd2:    e = '{OFS_ZERO, OFS_DEC,  GRP_A};
      4'd3:    e = '{OFS_DEC,  OFS_DEC,  GRP_A};
      4'd4:    e = '{OFS_INC,  OFS_ZERO, GRP_B};
      4'd5:    e = '{OFS_ZERO, OFS_INC,  GRP_B};
      4'd6:    e = '{OFS_INC,  OFS_INC,  GRP_B};
      4'd7:    e = '{OFS_INC,  OFS_DEC,  GRP_C};
      4'd8:    e = '{OFS_DEC,  OFS_INC,  GRP_D};
      default: e = '{OFS_ZERO, OFS_ZERO, GRP_CTR};
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

// File: src/point_splat_depth_image_raster_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Splat: two bit-serial dividers, then nine read/write pairs on the single pixel memory;
// a point that misses skips the read/write pairs. Read: an issue state, then a data state.
// Clear: writes the floor depth, zero gray and zero intensity to every memory word.
// One command is in flight at a time; the next is taken once the result is registered.
// After reset the memory is swept once before the first command is taken;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// Point splat depth image raster
// Bins points into a depth / gray / intensity image held in one memory.
// ----------------------------------------------------------------------------
module point_splat_depth_image_raster_top #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // px, py, pz, pint, rd_row, rd_col
  input  wire  [119:0] s_axis_tdata,
  // cmd
  input  wire  [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // depth_out, gray_out, inten_out, accepted, done_res, zero fill
  output logic [55:0]  m_axis_tdata,
  input  wire          cfg_valid_i,
  output logic         cfg_ready_o,
  input  wire  [2:0]   cfg_index_i,
  input  wire  [31:0]  cfg_data_i
);
  import psdr_pkg::*;

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int AW  = RW + CW;
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_DIV, ST_RMW_RD, ST_RMW_WR, ST_RD_ISSUE, ST_RD_DATA,
    ST_CLEAR, ST_OUT
  } state_e;

  logic [31:0] x_origin_q, y_origin_q, z_floor_q, gray_scale_q;
  logic [30:0] x_pitch_q, y_pitch_q;
  logic [8:0]  rows_used_q, cols_used_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_origin_q   <= '0;
      y_origin_q   <= '0;
      z_floor_q    <= '0;
      x_pitch_q    <= 31'd65536;
      y_pitch_q    <= 31'd65536;
      gray_scale_q <= 32'd65536;
      rows_used_q  <= 9'd256;
      cols_used_q  <= 9'd256;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_X_ORIGIN:   x_origin_q   <= cfg_data_i;
        REG_Y_ORIGIN:   y_origin_q   <= cfg_data_i;
        REG_Z_FLOOR:    z_floor_q    <= cfg_data_i;
        REG_X_PITCH:    x_pitch_q    <= cfg_data_i[30:0];
        REG_Y_PITCH:    y_pitch_q    <= cfg_data_i[30:0];
        REG_GRAY_SCALE: gray_scale_q <= cfg_data_i;
        REG_ROWS_USED:  rows_used_q  <= cfg_data_i[8:0];
        REG_COLS_USED:  cols_used_q  <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  logic [RCW-1:0] eff_rows;
  logic [CCW-1:0] eff_cols;
  assign eff_rows = (32'(rows_used_q) > 32'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(rows_used_q);
  assign eff_cols = (32'(cols_used_q) > 32'(MAX_COLS)) ? CCW'(MAX_COLS) : CCW'(cols_used_q);

  logic [1:0]  in_cmd;
  logic [31:0] in_px, in_py, in_pz;
  logic [7:0]  in_pint, in_rd_row, in_rd_col;
  assign in_cmd    = s_axis_tuser;
  assign in_px     = s_axis_tdata[31:0];
  assign in_py     = s_axis_tdata[63:32];
  assign in_pz     = s_axis_tdata[95:64];
  assign in_pint   = s_axis_tdata[103:96];
  assign in_rd_row = s_axis_tdata[111:104];
  assign in_rd_col = s_axis_tdata[119:112];

  logic signed [32:0] dx, dy, dz;
  assign dx = {in_px[31], in_px} - {x_origin_q[31], x_origin_q};
  assign dy = {in_py[31], in_py} - {y_origin_q[31], y_origin_q};
  assign dz = {in_pz[31], in_pz} - {z_floor_q[31], z_floor_q};

  logic rd_hit;
  assign rd_hit = (32'(in_rd_row) < 32'(eff_rows)) && (32'(in_rd_col) < 32'(eff_cols));

  // Pixel memory with registered read data.
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic          mem_we;
  pixel_t        mem_wdata, mem_rdata_q;
  pixel_t        mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[mem_raddr];
  end

  state_e        state_q;
  logic [AW-1:0] cnt_q;
  logic [4:0]    div_cnt_q;
  logic [31:0]   xq_q, yq_q, xrem_q, yrem_q;
  logic [30:0]   xdiv_q, ydiv_q;
  logic          xpos_q, ypos_q, zpos_q;
  logic [31:0]   dzmag_q, depth_q;
  logic [63:0]   prod_q;
  logic [7:0]    inten_q;
  logic [RW-1:0] r_q;
  logic [CW-1:0] c_q;
  logic [AW-1:0] addr_q;
  logic          rd_hit_q;
  logic [3:0]    k_q;
  logic [31:0]   fill_q;
  logic [49:0]   res_q;
  logic          out_valid_q;
  logic [49:0]   out_data_q;

  logic [32:0] xrem_sh, yrem_sh;
  assign xrem_sh = {xrem_q, xq_q[31]};
  assign yrem_sh = {yrem_q, yq_q[31]};

  logic [31:0] qx, qy;
  logic        hit;
  assign qx  = {xq_q[30:0], xrem_sh >= 33'(xdiv_q)};
  assign qy  = {yq_q[30:0], yrem_sh >= 33'(ydiv_q)};
  assign hit = xpos_q && ypos_q && (qx != '0) && (qy != '0)
               && (qx < 32'(eff_cols)) && (qy < 32'(eff_rows));

  logic [7:0] gray_v;
  assign gray_v = !zpos_q ? 8'd0 :
                  (prod_q[63:32] > 32'(GRAY_MAX)) ? 8'(GRAY_MAX) : prod_q[39:32];

  nb_t           nb;
  logic          lo_r, lo_c, hi_r, hi_c, nb_en;
  logic [RW-1:0] nb_r;
  logic [CW-1:0] nb_c;
  assign nb   = nb_entry(k_q);
  assign lo_r = r_q > RW'(1);
  assign lo_c = c_q > CW'(1);
  assign hi_r = (32'(r_q) + 32'd1) < 32'(eff_rows);
  assign hi_c = (32'(c_q) + 32'd1) < 32'(eff_cols);

  always_comb begin
    case (nb.grp)
      GRP_A:   nb_en = lo_r && lo_c;
      GRP_B:   nb_en = hi_r && hi_c;
      GRP_C:   nb_en = hi_r && lo_c;
      GRP_D:   nb_en = lo_r && hi_c;
      default: nb_en = 1'b1;
    endcase
    case (nb.row_ofs)
      OFS_DEC: nb_r = r_q - RW'(1);
      OFS_INC: nb_r = r_q + RW'(1);
      default: nb_r = r_q;
    endcase
    case (nb.col_ofs)
      OFS_DEC: nb_c = c_q - CW'(1);
      OFS_INC: nb_c = c_q + CW'(1);
      default: nb_c = c_q;
    endcase
  end

  pixel_t fill_px;
  always_comb begin
    fill_px = mem_rdata_q;
    if (k_q == 4'd0 || mem_rdata_q.depth == z_floor_q) fill_px.depth = depth_q;
    if (k_q == 4'd0 || mem_rdata_q.gray == 8'd0)       fill_px.gray  = gray_v;
    if (k_q == 4'd0 || mem_rdata_q.inten == 8'd0)      fill_px.inten = inten_q;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {nb_r, nb_c};
    mem_wdata = fill_px;
    mem_raddr = {nb_r, nb_c};
    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = '{8'd0, 8'd0, fill_q};
      end
      ST_RMW_WR:   mem_we = nb_en;
      ST_RD_ISSUE: mem_raddr = addr_q;
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_data_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
      k_q         <= '0;
    end else begin
      if (out_valid_q && m_axis_tready && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      prod_q <= 64'(dzmag_q) * 64'(gray_scale_q);
      unique case (state_q)
        ST_INIT: begin
          cnt_q <= cnt_q + AW'(1);
          if (cnt_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            res_q    <= '0;
            xq_q     <= dx[31:0];
            yq_q     <= dy[31:0];
            xpos_q   <= !dx[32] && (dx != '0);
            ypos_q   <= !dy[32] && (dy != '0);
            zpos_q   <= !dz[32] && (dz != '0);
            dzmag_q  <= dz[31:0];
            xrem_q   <= '0;
            yrem_q   <= '0;
            xdiv_q   <= (x_pitch_q == '0) ? 31'd1 : x_pitch_q;
            ydiv_q   <= (y_pitch_q == '0) ? 31'd1 : y_pitch_q;
            depth_q  <= in_pz;
            inten_q  <= in_pint;
            div_cnt_q <= '0;
            k_q      <= '0;
            rd_hit_q <= rd_hit;
            addr_q   <= {RW'(32'(eff_rows) - 32'd1 - 32'(in_rd_row)), CW'(in_rd_col)};
            fill_q   <= z_floor_q;
            cnt_q    <= '0;
            case (in_cmd)
              CMD_SPLAT: state_q <= ST_DIV;
              CMD_READ:  state_q <= ST_RD_ISSUE;
              CMD_CLEAR: state_q <= ST_CLEAR;
              default:   state_q <= ST_OUT;
            endcase
          end
        end
        ST_DIV: begin
          xrem_q    <= (xrem_sh >= 33'(xdiv_q)) ? 32'(xrem_sh - 33'(xdiv_q)) : xrem_sh[31:0];
          yrem_q    <= (yrem_sh >= 33'(ydiv_q)) ? 32'(yrem_sh - 33'(ydiv_q)) : yrem_sh[31:0];
          xq_q      <= qx;
          yq_q      <= qy;
          div_cnt_q <= div_cnt_q + 5'd1;
          if (div_cnt_q == '1) begin
            r_q <= RW'(qy);
            c_q <= CW'(qx);
            res_q[49] <= 1'b1;
            if (hit) begin
              res_q[48] <= 1'b1;
              state_q   <= ST_RMW_RD;
            end else begin
              state_q <= ST_OUT;
            end
          end
        end
        ST_RMW_RD: state_q <= ST_RMW_WR;
        ST_RMW_WR: begin
          k_q <= k_q + 4'd1;
          state_q <= (k_q == NB_LAST) ? ST_OUT : ST_RMW_RD;
        end
        ST_RD_ISSUE: state_q <= ST_RD_DATA;
        ST_RD_DATA: begin
          res_q[49] <= 1'b1;
          if (rd_hit_q) begin
            res_q[47:0] <= mem_rdata_q;
          end
          state_q <= ST_OUT;
        end
        ST_CLEAR: begin
          cnt_q <= cnt_q + AW'(1);
          if (cnt_q == '1) begin
            res_q[49] <= 1'b1;
            state_q   <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= res_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point splat depth image raster testbench
// Sends splat, read, clear and unused commands over the input stream and
// compares every output transfer with a cycle-free model of the pixel store.
// A short table of directed commands opens the run. Four configuration phases
// with random commands follow; the first two insert idle gaps, the last two
// none, and one phase holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_top;
  import psdr_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int unsigned NPIX = 256 * 256;
  localparam longint unsigned CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic        done;
    logic        acc;
    logic [7:0]  inten;
    logic [7:0]  gray;
    logic [31:0] depth;
  } pix_res_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [7:0]  pint;
    logic [7:0]  rd_row;
    logic [7:0]  rd_col;
  } cmd_item_t;

  typedef struct packed {
    cmd_item_t item;
    logic      fixed;
    pix_res_t  res;
  } dir_row_t;

  localparam pix_res_t NO_PIX   = '{1'b1, 1'b0, 8'd0, 8'd0, 32'd0};
  localparam pix_res_t NO_RES   = '{1'b0, 1'b0, 8'd0, 8'd0, 32'd0};
  localparam pix_res_t ANY      = '{1'b0, 1'b0, 8'd0, 8'd0, 32'd0};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic [119:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tready = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  wire s_axis_tready;
  wire m_axis_tvalid;
  wire [55:0] m_axis_tdata;
  wire cfg_ready_o;

  point_splat_depth_image_raster_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Model state: configuration and the pixel store.
  logic [31:0] m_x_origin, m_y_origin, m_z_floor, m_gray_scale;
  logic [30:0] m_x_pitch, m_y_pitch;
  logic [8:0]  m_rows, m_cols;
  logic [31:0] img_depth [NPIX];
  logic [7:0]  img_gray [NPIX];
  logic [7:0]  img_inten [NPIX];

  pix_res_t pending_px [$];
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  bit hold_go = 1'b0;
  int fails = 0;
  int n_hits = 0;
  int n_reads = 0;
  int n_clears = 0;
  int n_items = 0;
  longint unsigned cyc = 0;
  int last_r = 1;
  int last_c = 1;

  function automatic int eff_rows();
    return (m_rows > 256) ? 256 : int'(m_rows);
  endfunction

  function automatic int eff_cols();
    return (m_cols > 256) ? 256 : int'(m_cols);
  endfunction

  function automatic void wipe_image();
    for (int i = 0; i < NPIX; i++) begin
      img_depth[i] = m_z_floor;
      img_gray[i] = 8'd0;
      img_inten[i] = 8'd0;
    end
  endfunction

  function automatic void set_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      REG_X_ORIGIN:   m_x_origin = val;
      REG_Y_ORIGIN:   m_y_origin = val;
      REG_Z_FLOOR:    m_z_floor = val;
      REG_X_PITCH:    m_x_pitch = val[30:0];
      REG_Y_PITCH:    m_y_pitch = val[30:0];
      REG_GRAY_SCALE: m_gray_scale = val;
      REG_ROWS_USED:  m_rows = val[8:0];
      REG_COLS_USED:  m_cols = val[8:0];
      default: ;
    endcase
  endfunction

  function automatic longint cell_of(logic [31:0] coord, logic [31:0] origin,
                                     logic [30:0] pitch);
    longint d;
    longint p;
    d = longint'(signed'(coord)) - longint'(signed'(origin));
    p = (pitch == 0) ? 64'sd1 : longint'({33'd0, pitch});
    return d / p;
  endfunction

  function automatic logic [7:0] gray_of_z(logic [31:0] z);
    longint dz;
    longint unsigned u, hi, lo, v;
    dz = longint'(signed'(z)) - longint'(signed'(m_z_floor));
    if (dz <= 0) return 8'd0;
    u = longint'(dz);
    hi = (u >> 16) * longint'({32'd0, m_gray_scale});
    lo = (u & 64'hFFFF) * longint'({32'd0, m_gray_scale});
    v = (hi + (lo >> 16)) >> 16;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic void fill_empty(int r, int c, logic [31:0] d, logic [7:0] g,
                                     logic [7:0] it);
    int a;
    a = r * 256 + c;
    if (img_depth[a] == m_z_floor) img_depth[a] = d;
    if (img_gray[a] == 8'd0) img_gray[a] = g;
    if (img_inten[a] == 8'd0) img_inten[a] = it;
  endfunction

  function automatic pix_res_t raster_step(cmd_item_t it);
    pix_res_t res;
    longint ic, ir;
    int rows, cols, r, c, a;
    logic [7:0] g;
    bit lr, lc, hr, hc;
    res = NO_RES;
    rows = eff_rows();
    cols = eff_cols();
    case (it.cmd)
      CMD_SPLAT: begin
        ic = cell_of(it.px, m_x_origin, m_x_pitch);
        ir = cell_of(it.py, m_y_origin, m_y_pitch);
        if (ic > 0 && ir > 0 && ic < cols && ir < rows) begin
          c = int'(ic);
          r = int'(ir);
          g = gray_of_z(it.pz);
          a = r * 256 + c;
          img_depth[a] = it.pz;
          img_gray[a] = g;
          img_inten[a] = it.pint;
          lr = r > 1;
          lc = c > 1;
          hr = r + 1 < rows;
          hc = c + 1 < cols;
          if (lr && lc) begin
            fill_empty(r - 1, c, it.pz, g, it.pint);
            fill_empty(r, c - 1, it.pz, g, it.pint);
            fill_empty(r - 1, c - 1, it.pz, g, it.pint);
          end
          if (hr && hc) begin
            fill_empty(r + 1, c, it.pz, g, it.pint);
            fill_empty(r, c + 1, it.pz, g, it.pint);
            fill_empty(r + 1, c + 1, it.pz, g, it.pint);
          end
          if (hr && lc) fill_empty(r + 1, c - 1, it.pz, g, it.pint);
          if (lr && hc) fill_empty(r - 1, c + 1, it.pz, g, it.pint);
          res.acc = 1'b1;
          n_hits++;
        end
        res.done = 1'b1;
      end
      CMD_READ: begin
        if (it.rd_row < rows && it.rd_col < cols) begin
          a = (rows - 1 - int'(it.rd_row)) * 256 + int'(it.rd_col);
          res.depth = img_depth[a];
          res.gray = img_gray[a];
          res.inten = img_inten[a];
        end
        res.done = 1'b1;
        n_reads++;
      end
      CMD_CLEAR: begin
        wipe_image();
        res.done = 1'b1;
        n_clears++;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_cmd(cmd_item_t it, bit fixed, pix_res_t fixed_res);
    pix_res_t p;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.cmd;
    s_axis_tdata <= {it.rd_col, it.rd_row, it.pint, it.pz, it.py, it.px};
    do @(posedge clk_i); while (!s_axis_tready);
    p = raster_step(it);
    pending_px.push_back(fixed ? fixed_res : p);
    n_items++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    set_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic cmd_item_t rand_item();
    cmd_item_t it;
    int k, rows, cols;
    longint p, v;
    it.px = $urandom();
    it.py = $urandom();
    it.pz = $urandom();
    it.pint = 8'($urandom_range(0, 255));
    it.rd_row = 8'($urandom_range(0, 255));
    it.rd_col = 8'($urandom_range(0, 255));
    rows = eff_rows();
    cols = eff_cols();
    k = $urandom_range(99);
    if (k < 55) begin
      it.cmd = CMD_SPLAT;
      if (cols >= 2 && rows >= 2) begin
        last_c = $urandom_range(1, cols - 1);
        last_r = $urandom_range(1, rows - 1);
        p = (m_x_pitch == 0) ? 1 : longint'({33'd0, m_x_pitch});
        v = longint'(signed'(m_x_origin)) + last_c * p + $urandom_range(0, p - 1);
        it.px = v[31:0];
        p = (m_y_pitch == 0) ? 1 : longint'({33'd0, m_y_pitch});
        v = longint'(signed'(m_y_origin)) + last_r * p + $urandom_range(0, p - 1);
        it.py = v[31:0];
      end
      case ($urandom_range(0, 4))
        0: it.pz = m_z_floor;
        1: it.pz = m_z_floor + $urandom_range(0, 32'hFFFFF);
        2: it.pz = $urandom();
        3: it.pz = m_z_floor - $urandom_range(0, 32'hFFFF);
        default: it.pz = 32'h7FFFFFFF;
      endcase
    end else if (k < 65) begin
      it.cmd = CMD_SPLAT;
    end else if (k < 97) begin
      it.cmd = CMD_READ;
      if (k < 90 && rows >= 2 && cols >= 2) begin
        it.rd_row = 8'(rows - 1 - ((last_r + $urandom_range(0, 2) - 1) % rows));
        it.rd_col = 8'((last_c + $urandom_range(0, 2) - 1) % cols);
      end
    end else begin
      it.cmd = CMD_NONE;
    end
    return it;
  endfunction

  dir_row_t dir_tab [19] = '{
    '{'{CMD_READ,  32'h0, 32'h0, 32'h0, 8'h00, 8'd0, 8'd0}, 1'b1, NO_PIX},
    '{'{CMD_READ,  32'h0, 32'h0, 32'h0, 8'h00, 8'd255, 8'd255}, 1'b1, NO_PIX},
    '{'{CMD_SPLAT, 32'h00010000, 32'h00010000, 32'h000A0000, 8'hFF, 8'd0, 8'd0},
      1'b0, ANY},
    '{'{CMD_SPLAT, 32'h00FFFFFF, 32'h00FF0000, 32'h7FFFFFFF, 8'h01, 8'd0, 8'd0},
      1'b0, ANY},
    '{'{CMD_SPLAT, 32'h00000000, 32'h00050000, 32'h00010000, 8'h11, 8'd0, 8'd0},
      1'b1, NO_PIX},
    '{'{CMD_SPLAT, 32'hFFFFFFFF, 32'h00050000, 32'h00010000, 8'h22, 8'd0, 8'd0},
      1'b1, NO_PIX},
    '{'{CMD_SPLAT, 32'h01000000, 32'h00050000, 32'h00010000, 8'h33, 8'd0, 8'd0},
      1'b1, NO_PIX},
    '{'{CMD_SPLAT, 32'h000A0000, 32'h000A0000, 32'h80000000, 8'h00, 8'd0, 8'd0},
      1'b0, ANY},
    '{'{CMD_SPLAT, 32'h000B0000, 32'h000A0000, 32'h00000000, 8'h5A, 8'd0, 8'd0},
      1'b0, ANY},
    '{'{CMD_READ,  32'h0, 32'h0, 32'h0, 8'h00, 8'd254, 8'd1}, 1'b0, ANY},
    '{'{CMD_READ,  32'h0, 32'h0, 32'h0, 8'h00, 8'd0, 8'd255}, 1'b0, ANY},
    '{'{CMD_READ,  32'h0, 32'h0, 32'h0, 8'h00, 8'd245, 8'd10}, 1'b0, ANY},
    '{'{CMD_READ,  32'h0, 32'h0, 32'h0, 8'h00, 8'd245, 8'd11}, 1'b0, ANY},
    '{'{CMD_READ,  32'h0, 32'h0, 32'h0, 8'h00, 8'd244, 8'd11}, 1'b0, ANY},
    '{'{CMD_NONE,  32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 8'd255, 8'd255},
      1'b1, NO_RES},
    '{'{CMD_SPLAT, 32'h00020000, 32'h00020000, 32'h00030000, 8'h77, 8'd0, 8'd0},
      1'b0, ANY},
    '{'{CMD_READ,  32'h0, 32'h0, 32'h0, 8'h00, 8'd253, 8'd1}, 1'b0, ANY},
    '{'{CMD_CLEAR, 32'h0, 32'h0, 32'h0, 8'h00, 8'd0, 8'd0}, 1'b1, NO_PIX},
    '{'{CMD_READ,  32'h0, 32'h0, 32'h0, 8'h00, 8'd254, 8'd1}, 1'b1, NO_PIX}
  };

  logic [31:0] phase_regs [4][8] = '{
    '{32'hFFCE0000, 32'hFFEC0000, 32'hFFFB0000, 32'h00018000,
      32'h00020000, 32'h00030000, 32'd200, 32'd256},
    '{32'h7FFFFFF0, 32'h80000000, 32'h80000000, 32'h00000000,
      32'h00000001, 32'hFFFFFFFF, 32'd4, 32'd3},
    '{32'h00000000, 32'h12345678, 32'h7FFF0000, 32'h00001000,
      32'h00000800, 32'h00000000, 32'd511, 32'd300},
    '{32'h80000000, 32'h7FFFFFFF, 32'h00000000, 32'h7FFFFFFF,
      32'h7FFFFFFF, 32'h00000001, 32'd0, 32'd0}
  };
  int phase_items [4] = '{280, 280, 280, 20};
  int phase_send_idle [4] = '{23, 64, 0, 0};
  int phase_recv_idle [4] = '{64, 23, 0, 0};

  always @(posedge clk_i) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    pix_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = pix_res_t'(m_axis_tdata[49:0]);
      if (pending_px.size() == 0) begin
        $error("output transfer with no result pending: %h", m_axis_tdata);
        fails++;
      end else begin
        want = pending_px.pop_front();
        if (got.depth !== want.depth) begin
          $error("depth_out: expected %h, got %h", want.depth, got.depth);
          fails++;
        end
        if (got.gray !== want.gray) begin
          $error("gray_out: expected %h, got %h", want.gray, got.gray);
          fails++;
        end
        if (got.inten !== want.inten) begin
          $error("inten_out: expected %h, got %h", want.inten, got.inten);
          fails++;
        end
        if (got.acc !== want.acc) begin
          $error("accepted: expected %b, got %b", want.acc, got.acc);
          fails++;
        end
        if (got.done !== want.done) begin
          $error("done_res: expected %b, got %b", want.done, got.done);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    cmd_item_t clr;
    m_x_origin = '0;
    m_y_origin = '0;
    m_z_floor = '0;
    m_x_pitch = 31'd65536;
    m_y_pitch = 31'd65536;
    m_gray_scale = 32'd65536;
    m_rows = 9'd256;
    m_cols = 9'd256;
    wipe_image();
    clr = '{CMD_CLEAR, 32'h0, 32'h0, 32'h0, 8'h00, 8'd0, 8'd0};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_cmd(dir_tab[i].item, dir_tab[i].fixed, dir_tab[i].res);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      send_idle = 0;
      recv_idle = 0;
      for (int r = 0; r < 8; r++) write_reg(r[2:0], phase_regs[ph][r]);
      send_cmd(clr, 1'b1, NO_PIX);
      send_idle = phase_send_idle[ph];
      recv_idle = phase_recv_idle[ph];
      for (int n = 0; n < phase_items[ph]; n++) begin
        if (ph == 2 && n == 20) hold_go = 1'b1;
        send_cmd(rand_item(), 1'b0, ANY);
      end
    end
    drain();

    $display("Sent %0d commands: %0d points landed, %0d reads, %0d clears,",
             n_items, n_hits, n_reads, n_clears);
    $display("over four register settings from the largest image down to an empty one.");
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
src/psdr_pkg.sv
src/point_splat_depth_image_raster_top.sv
dv/tb_top.sv
